// File: src/edf_pkg.sv
// Shared codes and fixed field widths for the EDF periodic task scheduler.
// No dependencies.
`timescale 1ns / 1ps

package edf_pkg;

	// fixed port widths
	localparam int TASK_IDX_W  = 4;
	localparam int NUM_TASKS_W = 5;
	localparam int ADDR_W      = 3;
	localparam int REG_SEL_BIT = 2;

	// register selects (paddr[REG_SEL_BIT])
	localparam logic REG_NUM_TASKS = 1'b0;
	localparam logic REG_MAX_TICKS = 1'b1;

	// command codes
	localparam logic FN_LOAD = 1'b0;
	localparam logic FN_TICK = 1'b1;

	// result status codes
	localparam logic [1:0] ST_RAN  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_HALT = 2'd3;

	localparam int MAX_TICKS_RST = 30;

endpackage

// File: src/edf_periodic_task_scheduler_core.sv
// EDF periodic task scheduler: task tables, run state and the per-tick scan sequencer.
// Depends on edf_pkg.
`timescale 1ns / 1ps

// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+---------------------------------------------
// command   | start, busy (transfer: start&!busy) | func, task_index, duration, rel_deadline, period
// result    | res_valid (one-cycle strobe)      | time_res, status, task_sel, remaining,
//           |                                   | abs_deadline, task_done
// config    | APB psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A load transfer never raises busy. A tick on a halted or expired run reports status halted
// in the next cycle without raising busy. Any other tick holds busy while the scan reads each
// active task entry in turn (none when no task is active) through the single read port of the
// run-state memory, then drains the read stage and commits the chosen task; a missed deadline
// ends the scan early. The result strobe rises in the same cycle that busy drops.
// Reset clears all control state and the valid bits of the run state; tables are undefined
// until loaded. The receiver cannot stall: a result is presented for exactly one cycle.

module edf_periodic_task_scheduler_core #(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [edf_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// command channel
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [edf_pkg::TASK_IDX_W-1:0] task_index,
	input  logic [TIME_BITS-1:0]           duration,
	input  logic [TIME_BITS-1:0]           rel_deadline,
	input  logic [TIME_BITS-1:0]           period,
	// result channel
	output logic                           res_valid,
	output logic [TIME_BITS-1:0]           time_res,
	output logic [1:0]                     status,
	output logic [edf_pkg::TASK_IDX_W-1:0] task_sel,
	output logic [TIME_BITS-1:0]           remaining,
	output logic [TIME_BITS:0]             abs_deadline,
	output logic                           task_done
);
	import edf_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int DL_W  = TIME_BITS + 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	typedef struct packed {
		logic [TIME_BITS-1:0] dur;
		logic [TIME_BITS-1:0] reldl;
		logic [TIME_BITS-1:0] period;
	} task_cfg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] work;
		logic [DL_W-1:0]      dl;
		logic [DL_W-1:0]      rel;
	} run_ent_t;

	// memories
	task_cfg_t cfg_mem [MAX_TASKS];
	run_ent_t  run_mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] run_vld_q;

	// control
	logic [1:0]             state_q;
	logic [NUM_TASKS_W-1:0] num_tasks_q;
	logic [TIME_BITS-1:0]   max_ticks_q;
	logic [TIME_BITS-1:0]   now_q;
	logic                   halted_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       rd_cnt_q;

	// read stage
	logic                   live_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   vld_s1;
	run_ent_t               run_rd_s1;
	task_cfg_t              cfg_rd_s1;

	// best candidate so far
	logic                   best_vld_q;
	logic [IDX_W-1:0]       best_idx_q;
	run_ent_t               best_q;

	// result registers
	logic                   res_valid_q;
	logic [TIME_BITS-1:0]   time_res_q;
	logic [1:0]             status_q;
	logic [TASK_IDX_W-1:0]  task_sel_q;
	logic [TIME_BITS-1:0]   remaining_q;
	logic [DL_W-1:0]        abs_deadline_q;
	logic                   task_done_q;

	logic                   cfg_wr;
	logic                   accept;
	logic                   load_ok;
	logic                   run_over;
	logic [CNT_W-1:0]       n_clamp;
	logic                   issue;
	logic                   proc;
	run_ent_t               ent;
	logic [DL_W-1:0]        now_ext;
	logic                   miss;
	logic                   release_now;
	run_ent_t               rel_ent;
	logic                   better;
	logic [TIME_BITS-1:0]   best_dec;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_idx;
	run_ent_t               wr_data;

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_NUM_TASKS: prdata = 32'(num_tasks_q);
			REG_MAX_TICKS: prdata = 32'(max_ticks_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q <= '0;
			max_ticks_q <= TIME_BITS'(MAX_TICKS_RST);
		end else if (cfg_wr) begin
			unique case (paddr[REG_SEL_BIT])
				REG_NUM_TASKS: num_tasks_q <= pwdata[NUM_TASKS_W-1:0];
				REG_MAX_TICKS: max_ticks_q <= pwdata[TIME_BITS-1:0];
				default:       ;
			endcase
		end
	end

	// ---------------- command decode ----------------
	assign busy     = (state_q != S_IDLE);
	assign accept   = start & ~busy;
	assign load_ok  = (32'(task_index) < MAX_TASKS);
	assign run_over = halted_q | (now_q >= max_ticks_q);
	assign n_clamp  = (32'(num_tasks_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(num_tasks_q);

	// one entry read per cycle while the scan still has entries to fetch
	assign issue = (state_q == S_SCAN) && (rd_cnt_q < n_q);
	assign proc  = (state_q == S_SCAN) && live_s1;

	// ---------------- per-entry unit ----------------
	// miss check sees the state before release; candidate compare sees it after
	always_comb begin
		ent         = vld_s1 ? run_rd_s1 : '0;
		now_ext     = {1'b0, now_q};
		miss        = (ent.work != '0) && (now_ext >= ent.dl);
		release_now = (now_ext == ent.rel);
		rel_ent     = ent;
		if (release_now) begin
			rel_ent.work = cfg_rd_s1.dur;
			rel_ent.dl   = now_ext + {1'b0, cfg_rd_s1.reldl};
			rel_ent.rel  = ent.rel + {1'b0, cfg_rd_s1.period};
		end
		better   = (rel_ent.work != '0) && (!best_vld_q || (rel_ent.dl < best_q.dl));
		best_dec = best_q.work - TIME_BITS'(1);
	end

	// single write port: released entry during the scan, chosen task at the end
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = idx_s1;
		wr_data = rel_ent;
		if (state_q == S_FINISH) begin
			wr_en        = best_vld_q;
			wr_idx       = best_idx_q;
			wr_data      = best_q;
			wr_data.work = best_dec;
		end else if (proc && !miss && release_now) begin
			wr_en = 1'b1;
		end
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (accept && func == FN_LOAD && load_ok) begin
			cfg_mem[IDX_W'(task_index)] <= '{dur: duration, reldl: rel_deadline, period: period};
		end
		if (wr_en) begin
			run_mem[wr_idx] <= wr_data;
		end
		run_rd_s1 <= run_mem[rd_cnt_q[IDX_W-1:0]];
		cfg_rd_s1 <= cfg_mem[rd_cnt_q[IDX_W-1:0]];
		vld_s1    <= run_vld_q[rd_cnt_q[IDX_W-1:0]];
		idx_s1    <= rd_cnt_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_vld_q <= '0;
		end else if (accept && func == FN_LOAD) begin
			run_vld_q <= '0;
		end else if (wr_en) begin
			run_vld_q[wr_idx] <= 1'b1;
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			now_q      <= '0;
			halted_q   <= 1'b0;
			n_q        <= '0;
			rd_cnt_q   <= '0;
			live_s1    <= 1'b0;
			best_vld_q <= 1'b0;
			best_idx_q <= '0;
			best_q     <= '0;
		end else begin
			live_s1 <= issue;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FN_LOAD) begin
							now_q    <= '0;
							halted_q <= 1'b0;
						end else if (!run_over) begin
							n_q        <= n_clamp;
							rd_cnt_q   <= '0;
							best_vld_q <= 1'b0;
							state_q    <= (n_clamp == '0) ? S_FINISH : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (proc && miss) begin
						halted_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						if (proc && better) begin
							best_vld_q <= 1'b1;
							best_idx_q <= idx_s1;
							best_q     <= rel_ent;
						end
						if (!issue) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					now_q   <= now_q + TIME_BITS'(1);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (accept && func == FN_TICK && run_over)
				|| (proc && miss) || (state_q == S_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		time_res_q     <= now_q;
		status_q       <= ST_HALT;
		task_sel_q     <= '0;
		remaining_q    <= '0;
		abs_deadline_q <= '0;
		task_done_q    <= 1'b0;
		if (proc && miss) begin
			status_q       <= ST_MISS;
			task_sel_q     <= TASK_IDX_W'(idx_s1);
			remaining_q    <= ent.work;
			abs_deadline_q <= ent.dl;
		end else if (state_q == S_FINISH) begin
			if (best_vld_q) begin
				status_q       <= ST_RAN;
				task_sel_q     <= TASK_IDX_W'(best_idx_q);
				remaining_q    <= best_dec;
				abs_deadline_q <= best_q.dl;
				task_done_q    <= (best_dec == '0);
			end else begin
				status_q <= ST_IDLE;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign time_res     = time_res_q;
	assign status       = status_q;
	assign task_sel     = task_sel_q;
	assign remaining    = remaining_q;
	assign abs_deadline = abs_deadline_q;
	assign task_done    = task_done_q;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for edf_periodic_task_scheduler_core: directed and random
// load/tick traffic, APB register writes with readback, and a scoreboard class.
// Depends on edf_pkg and the scheduler core.
`timescale 1ns / 1ps

module testbench;
	import edf_pkg::*;

	localparam int TW         = 15;     // time / work field width of the build under test
	localparam int NTASK      = 16;     // task table depth of the build under test
	localparam int ITEM_GOAL  = 1300;   // no new random phase starts once this many commands went in
	localparam int SETTLE     = 6;      // quiet cycles after the last result before a reg write
	localparam int TAIL       = 24;     // quiet cycles at the end of the run
	localparam int WDOG_LIMIT = 2000;   // cycles without any transfer before giving up

	// one command transfer
	typedef struct {
		logic          fn;
		logic [3:0]    idx;
		logic [TW-1:0] dur;
		logic [TW-1:0] rdl;
		logic [TW-1:0] per;
	} sched_cmd_t;

	// one tick report
	typedef struct {
		logic [TW-1:0] t;
		logic [1:0]    st;
		logic [3:0]    sel;
		logic [TW-1:0] rem;
		logic [TW:0]   dl;
		logic          done;
	} sched_res_t;

	// Scoreboard: keeps its own copy of the task tables, run state and registers,
	// computes the report of every accepted tick and matches the reports in order.
	class edf_scoreboard;
		bit [TW-1:0] dur_tab[NTASK];
		bit [TW-1:0] rdl_tab[NTASK];
		bit [TW-1:0] per_tab[NTASK];
		bit [TW-1:0] work[NTASK];
		bit [TW:0]   dl_abs[NTASK];
		bit [TW:0]   rel_at[NTASK];
		bit [TW-1:0] t_now;
		bit          stopped;
		bit [4:0]    ntask_reg;
		bit [TW-1:0] maxt_reg;
		sched_res_t  due_q[$];
		int          errors;
		int          n_ran, n_idle, n_miss, n_halt;

		function new();
			foreach (dur_tab[i]) begin
				dur_tab[i] = '0;
				rdl_tab[i] = '0;
				per_tab[i] = '0;
			end
			clear_run();
			ntask_reg = '0;
			maxt_reg  = TW'(MAX_TICKS_RST);
			errors    = 0;
			n_ran = 0; n_idle = 0; n_miss = 0; n_halt = 0;
		endfunction

		function void clear_run();
			foreach (work[i]) begin
				work[i]   = '0;
				dl_abs[i] = '0;
				rel_at[i] = '0;
			end
			t_now   = '0;
			stopped = 1'b0;
		endfunction

		function void set_reg(logic sel, logic [31:0] v);
			if (sel == REG_NUM_TASKS)
				ntask_reg = v[4:0];
			else
				maxt_reg = v[TW-1:0];
		endfunction

		function void check_reg(logic sel, logic [31:0] rd);
			logic [31:0] want;
			logic [31:0] got;
			want = (sel == REG_NUM_TASKS) ? 32'(ntask_reg) : 32'(maxt_reg);
			got  = (sel == REG_NUM_TASKS) ? 32'(rd[4:0]) : 32'(rd[TW-1:0]);
			cmp_field(sel == REG_NUM_TASKS ? "prdata(num_tasks)" : "prdata(max_ticks)",
				want, got);
		endfunction

		function void push_report(logic [1:0] st, int sel, logic [TW-1:0] rem,
				logic [TW:0] dl, logic done);
			sched_res_t r;
			r.t    = t_now;
			r.st   = st;
			r.sel  = 4'(sel);
			r.rem  = rem;
			r.dl   = dl;
			r.done = done;
			due_q.push_back(r);
		endfunction

		// advance the schedule for one accepted command
		function void note_cmd(sched_cmd_t c);
			int n;
			int best;
			if (c.fn == FN_LOAD) begin
				dur_tab[c.idx] = c.dur;
				rdl_tab[c.idx] = c.rdl;
				per_tab[c.idx] = c.per;
				clear_run();
				return;
			end
			if (stopped || t_now >= maxt_reg) begin
				push_report(ST_HALT, 0, '0, '0, 1'b0);
				return;
			end
			n = (ntask_reg > NTASK) ? NTASK : int'(ntask_reg);
			// missed deadline check comes first and ends the tick
			for (int i = 0; i < n; i++) begin
				if (work[i] != 0 && {1'b0, t_now} >= dl_abs[i]) begin
					stopped = 1'b1;
					push_report(ST_MISS, i, work[i], dl_abs[i], 1'b0);
					return;
				end
			end
			for (int i = 0; i < n; i++) begin
				if ({1'b0, t_now} == rel_at[i]) begin
					work[i]   = dur_tab[i];
					dl_abs[i] = {1'b0, t_now} + {1'b0, rdl_tab[i]};
					rel_at[i] = rel_at[i] + {1'b0, per_tab[i]};
				end
			end
			// earliest deadline, strict compare keeps the lowest index on a tie
			best = -1;
			for (int i = 0; i < n; i++) begin
				if (work[i] != 0 && (best < 0 || dl_abs[i] < dl_abs[best]))
					best = i;
			end
			if (best < 0) begin
				push_report(ST_IDLE, 0, '0, '0, 1'b0);
			end else begin
				work[best] = work[best] - 1'b1;
				push_report(ST_RAN, best, work[best], dl_abs[best], work[best] == 0);
			end
			t_now = t_now + 1'b1;
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_res(sched_res_t r);
			sched_res_t e;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t unexpected report: status %0d task %0d at time %0d",
					$time, r.st, r.sel, r.t);
				return;
			end
			e = due_q.pop_front();
			cmp_field("time_res", 32'(e.t), 32'(r.t));
			cmp_field("status", 32'(e.st), 32'(r.st));
			cmp_field("task_sel", 32'(e.sel), 32'(r.sel));
			cmp_field("remaining", 32'(e.rem), 32'(r.rem));
			cmp_field("abs_deadline", 32'(e.dl), 32'(r.dl));
			cmp_field("task_done", 32'(e.done), 32'(r.done));
			case (e.st)
				ST_RAN:  n_ran++;
				ST_IDLE: n_idle++;
				ST_MISS: n_miss++;
				default: n_halt++;
			endcase
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  start;
	logic                  busy;
	logic                  func;
	logic [TASK_IDX_W-1:0] task_index;
	logic [TW-1:0]         duration, rel_deadline, period;
	logic                  res_valid;
	logic [TW-1:0]         time_res;
	logic [1:0]            status;
	logic [TASK_IDX_W-1:0] task_sel;
	logic [TW-1:0]         remaining;
	logic [TW:0]           abs_deadline;
	logic                  task_done;

	edf_scoreboard sched_sb;
	int            cmds_sent;
	int            phases;
	int            idle_cycles;
	bit            no_idle;     // phases with back-to-back commands

	edf_periodic_task_scheduler_core #(
		.MAX_TASKS(NTASK),
		.TIME_BITS(TW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.func(func),
		.task_index(task_index),
		.duration(duration),
		.rel_deadline(rel_deadline),
		.period(period),
		.res_valid(res_valid),
		.time_res(time_res),
		.status(status),
		.task_sel(task_sel),
		.remaining(remaining),
		.abs_deadline(abs_deadline),
		.task_done(task_done)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result monitor: the receiver never stalls, every strobe is one transfer.
	always @(posedge clk) begin
		sched_res_t r;
		if (arst_n && res_valid) begin
			r.t    = time_res;
			r.st   = status;
			r.sel  = task_sel;
			r.rem  = remaining;
			r.dl   = abs_deadline;
			r.done = task_done;
			sched_sb.check_res(r);
		end
	end

	// Watchdog: any command, result or APB access counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || res_valid || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t watchdog expired, %0d reports outstanding", $time, sched_sb.pending());
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sender gap: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		else
			return $urandom_range(30, 80);
	endfunction

	function automatic logic [ADDR_W-1:0] reg_addr(logic sel);
		return ADDR_W'(sel) << REG_SEL_BIT;
	endfunction

	// Drive one command and hold it until the block takes it (start & !busy).
	task automatic send_cmd(logic fn, logic [3:0] idx, logic [TW-1:0] d,
			logic [TW-1:0] r, logic [TW-1:0] p);
		sched_cmd_t c;
		int gap;
		c.fn = fn; c.idx = idx; c.dur = d; c.rdl = r; c.per = p;
		start        <= 1'b1;
		func         <= fn;
		task_index   <= idx;
		duration     <= d;
		rel_deadline <= r;
		period       <= p;
		@(posedge clk);
		while (busy) @(posedge clk);
		sched_sb.note_cmd(c);
		cmds_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic tick();
		send_cmd(FN_TICK, 4'($urandom), TW'($urandom), TW'($urandom), TW'($urandom));
	endtask

	// Sender holds off until every report has come back, then lets the block settle.
	task automatic drain();
		start <= 1'b0;
		while (sched_sb.pending() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write (setup + access) followed by a readback of the same register.
	task automatic reg_write(logic sel, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= reg_addr(sel);
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sched_sb.set_reg(sel, v);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sched_sb.check_reg(sel, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One task entry: a plausible periodic task, or arbitrary full-width values.
	task automatic load_entry(logic [3:0] idx, bit sane);
		logic [TW-1:0] d, r, p;
		int lim;
		if (sane) begin
			p   = ($urandom_range(0, 9) == 0) ? '0 : TW'($urandom_range(2, 20));
			lim = (p == 0) ? 4 : ((int'(p) / 3 > 1) ? int'(p) / 3 : 1);
			d   = TW'($urandom_range(0, lim));
			if ($urandom_range(0, 4) != 0)
				r = TW'($urandom_range(int'(d), (p == 0) ? int'(d) + 12 : int'(p) + 2));
			else
				r = TW'($urandom_range(0, int'(d) + 1));
		end else begin
			d = ($urandom_range(0, 7) == 0) ? {TW{1'b1}} : TW'($urandom);
			r = ($urandom_range(0, 7) == 0) ? {TW{1'b1}} : TW'($urandom);
			p = ($urandom_range(0, 7) == 0) ? '0 : TW'($urandom);
		end
		send_cmd(FN_LOAD, idx, d, r, p);
	endtask

	// Random phase: new settings, usually a new task set, then a burst of ticks.
	task automatic run_phase();
		int r;
		int nt;
		int mt;
		int nticks;
		bit sane_set;
		r  = $urandom_range(0, 99);
		nt = (r < 8) ? 0 : (r < 18) ? NTASK : (r < 24) ? $urandom_range(NTASK + 1, 31)
			: $urandom_range(1, 6);
		r  = $urandom_range(0, 99);
		mt = (r < 4) ? 32767 : (r < 8) ? 1 : (r < 10) ? 0 : (r < 14) ? $urandom_range(0, 32767)
			: $urandom_range(10, 90);
		no_idle = ($urandom_range(0, 3) == 0);
		drain();
		if ($urandom_range(0, 9) < 7)
			reg_write(REG_NUM_TASKS, 32'(nt));
		if ($urandom_range(0, 9) < 7)
			reg_write(REG_MAX_TICKS, 32'(mt));
		// most phases load a fresh task set, usually well-formed; some keep the running schedule
		if ($urandom_range(0, 4) != 0) begin
			sane_set = ($urandom_range(0, 6) != 0);
			for (int i = 0; i < NTASK && i < nt; i++)
				load_entry(4'(i), sane_set || $urandom_range(0, 3) == 0);
			if (nt == 0)
				load_entry(4'($urandom), sane_set);
		end
		nticks = $urandom_range(5, 70);
		for (int k = 0; k < nticks; k++) begin
			if ($urandom_range(0, 24) == 0)
				load_entry(4'($urandom), $urandom_range(0, 1) == 1);
			else
				tick();
		end
		phases++;
	endtask

	initial begin
		sched_sb    = new();
		cmds_sent   = 0;
		phases      = 0;
		idle_cycles = 0;
		no_idle     = 1'b0;
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		start        <= 1'b0;
		func         <= FN_LOAD;
		task_index   <= '0;
		duration     <= '0;
		rel_deadline <= '0;
		period       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// no tasks configured: idle report at time zero
		tick();
		// zero max_ticks: every tick is halted
		drain();
		reg_write(REG_MAX_TICKS, 32'd0);
		tick();
		drain();
		reg_write(REG_MAX_TICKS, 32'(MAX_TICKS_RST));
		// fill every table entry before any task is enabled
		send_cmd(FN_LOAD, 4'd0, TW'(1), TW'(4), TW'(4));
		send_cmd(FN_LOAD, 4'd1, TW'(2), TW'(4), TW'(8));     // same deadline as entry 0
		send_cmd(FN_LOAD, 4'd2, TW'(0), TW'(5), TW'(5));     // zero duration, never runs
		for (int i = 3; i < NTASK - 1; i++)
			send_cmd(FN_LOAD, 4'(i), TW'(1), TW'(100 + i), TW'(0));
		send_cmd(FN_LOAD, 4'(NTASK - 1), {TW{1'b1}}, {TW{1'b1}}, '0);  // widest values
		drain();
		reg_write(REG_NUM_TASKS, 32'd3);
		repeat (3) tick();
		// more entries than the table holds: treated as all sixteen
		drain();
		reg_write(REG_NUM_TASKS, 32'd31);
		repeat (2) tick();
		// deadline one unit after release with three units of work: miss, then halted
		send_cmd(FN_LOAD, 4'd0, TW'(3), TW'(1), TW'(0));
		repeat (3) tick();

		// --- random part ---
		while (cmds_sent < ITEM_GOAL)
			run_phase();

		// --- wind-down ---
		drain();
		repeat (TAIL) @(posedge clk);
		$display("%0d commands over %0d random phases; reports: %0d ran, %0d idle,",
			cmds_sent, phases, sched_sb.n_ran, sched_sb.n_idle);
		$display("%0d missed deadline, %0d halted; %0d mismatches",
			sched_sb.n_miss, sched_sb.n_halt, sched_sb.errors);
		if (sched_sb.errors == 0 && sched_sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
src/edf_pkg.sv
src/edf_periodic_task_scheduler_core.sv
tb/sv/testbench.sv
